FILE: hdl/agbkf_pkg.sv
// Shared types, constants and a saturating helper function for the angle and gyro bias Kalman filter.
package agbkf_pkg;

    localparam int DT_FRAC  = 16;
    localparam int COV_FRAC = 24;
    localparam int DT_W     = 24;
    localparam int NOISE_W  = 31;
    localparam int DIV_W    = 32 + COV_FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int ADDR_W   = 5;

    localparam logic [NOISE_W-1:0] RST_QA   = NOISE_W'(16777);
    localparam logic [NOISE_W-1:0] RST_QB   = NOISE_W'(50332);
    localparam logic [NOISE_W-1:0] RST_R    = NOISE_W'(503316);
    localparam logic signed [31:0] RST_ANG  = 32'sd0;
    localparam logic signed [31:0] RST_BIAS = 32'sd0;
    localparam logic signed [31:0] RST_COVA = 32'sd167772160;
    localparam logic signed [31:0] RST_COVB = 32'sd167772160;
    localparam logic signed [31:0] RST_COVX = 32'sd0;

    typedef enum logic [2:0] {
        REG_QA   = 3'd0,
        REG_QB   = 3'd1,
        REG_R    = 3'd2,
        REG_ANG  = 3'd3,
        REG_BIAS = 3'd4,
        REG_COVA = 3'd5,
        REG_COVB = 3'd6,
        REG_COVX = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DT_W-1:0]    time_step;
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_rate;
    } in_data_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic               gain_skipped;
    } out_data_t;

    typedef struct packed {
        logic [NOISE_W-1:0] qa;
        logic [NOISE_W-1:0] qb;
        logic [NOISE_W-1:0] r;
        logic signed [31:0] init_angle;
        logic signed [31:0] init_bias;
        logic signed [31:0] init_cov_a;
        logic signed [31:0] init_cov_b;
        logic signed [31:0] init_cov_x;
    } cfg_t;

    typedef enum logic [3:0] {
        MOP_ANG_PRED,
        MOP_T,
        MOP_P00_PRED,
        MOP_P11_PRED,
        MOP_ANG_COR,
        MOP_BIAS,
        MOP_P11,
        MOP_P10,
        MOP_P01,
        MOP_P00
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_MUL_WB,
        ST_GAIN,
        ST_DIV_START,
        ST_DIV_STEP,
        ST_DIV_WB,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    prep;
        logic    mul_issue;
        logic    mul_wb;
        mul_op_t mul_op;
        logic    gain;
        logic    div_start;
        logic    div_step;
        logic    div_wb;
        logic    div_sel;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
    } dp_status_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: hdl/agbkf_regs.sv
// Configuration register file with APB-style access and a state reload pulse.
module agbkf_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [agbkf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output agbkf_pkg::cfg_t             cfg,
    output logic                        reload
);

    agbkf_pkg::cfg_t   cfg_reg;
    logic              reload_reg;
    agbkf_pkg::reg_idx_t idx;
    logic              wr;

    assign idx = agbkf_pkg::reg_idx_t'(paddr[agbkf_pkg::ADDR_W-1:2]);
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qa         <= agbkf_pkg::RST_QA;
            cfg_reg.qb         <= agbkf_pkg::RST_QB;
            cfg_reg.r          <= agbkf_pkg::RST_R;
            cfg_reg.init_angle <= agbkf_pkg::RST_ANG;
            cfg_reg.init_bias  <= agbkf_pkg::RST_BIAS;
            cfg_reg.init_cov_a <= agbkf_pkg::RST_COVA;
            cfg_reg.init_cov_b <= agbkf_pkg::RST_COVB;
            cfg_reg.init_cov_x <= agbkf_pkg::RST_COVX;
            reload_reg         <= 1'b0;
        end
        else
        begin
            reload_reg <= wr;
            if (wr)
            begin
                unique case (idx)
                    agbkf_pkg::REG_QA:   cfg_reg.qa <= pwdata[agbkf_pkg::NOISE_W-1:0];
                    agbkf_pkg::REG_QB:   cfg_reg.qb <= pwdata[agbkf_pkg::NOISE_W-1:0];
                    agbkf_pkg::REG_R:    cfg_reg.r  <= pwdata[agbkf_pkg::NOISE_W-1:0];
                    agbkf_pkg::REG_ANG:  cfg_reg.init_angle <= pwdata;
                    agbkf_pkg::REG_BIAS: cfg_reg.init_bias  <= pwdata;
                    agbkf_pkg::REG_COVA: cfg_reg.init_cov_a <= pwdata;
                    agbkf_pkg::REG_COVB: cfg_reg.init_cov_b <= pwdata;
                    agbkf_pkg::REG_COVX: cfg_reg.init_cov_x <= pwdata;
                    default:             cfg_reg.qa <= cfg_reg.qa;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            agbkf_pkg::REG_QA:   prdata = {1'b0, cfg_reg.qa};
            agbkf_pkg::REG_QB:   prdata = {1'b0, cfg_reg.qb};
            agbkf_pkg::REG_R:    prdata = {1'b0, cfg_reg.r};
            agbkf_pkg::REG_ANG:  prdata = cfg_reg.init_angle;
            agbkf_pkg::REG_BIAS: prdata = cfg_reg.init_bias;
            agbkf_pkg::REG_COVA: prdata = cfg_reg.init_cov_a;
            agbkf_pkg::REG_COVB: prdata = cfg_reg.init_cov_b;
            agbkf_pkg::REG_COVX: prdata = cfg_reg.init_cov_x;
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg    = cfg_reg;
    assign reload = reload_reg;

endmodule

FILE: hdl/agbkf_ctrl.sv
// Sequencer that steps the datapath through predict, gain and correct for one request.
module agbkf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  agbkf_pkg::dp_status_t status,
    output agbkf_pkg::dp_cmd_t    cmd
);

    agbkf_pkg::ctrl_state_t state_reg, state_next;
    agbkf_pkg::mul_op_t     op_reg, op_next;
    logic                   sel_reg, sel_next;
    logic [agbkf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;

    function automatic agbkf_pkg::mul_op_t next_op(input agbkf_pkg::mul_op_t op);
        unique case (op)
            agbkf_pkg::MOP_ANG_PRED: return agbkf_pkg::MOP_T;
            agbkf_pkg::MOP_T:        return agbkf_pkg::MOP_P00_PRED;
            agbkf_pkg::MOP_P00_PRED: return agbkf_pkg::MOP_P11_PRED;
            agbkf_pkg::MOP_P11_PRED: return agbkf_pkg::MOP_ANG_COR;
            agbkf_pkg::MOP_ANG_COR:  return agbkf_pkg::MOP_BIAS;
            agbkf_pkg::MOP_BIAS:     return agbkf_pkg::MOP_P11;
            agbkf_pkg::MOP_P11:      return agbkf_pkg::MOP_P10;
            agbkf_pkg::MOP_P10:      return agbkf_pkg::MOP_P01;
            agbkf_pkg::MOP_P01:      return agbkf_pkg::MOP_P00;
            default:                 return agbkf_pkg::MOP_ANG_PRED;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= agbkf_pkg::ST_IDLE;
            op_reg        <= agbkf_pkg::MOP_ANG_PRED;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_op     = op_reg;
        cmd.div_sel    = sel_reg;
        unique case (state_reg)
            agbkf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = agbkf_pkg::ST_PREP;
                end
            end
            agbkf_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                op_next    = agbkf_pkg::MOP_ANG_PRED;
                state_next = agbkf_pkg::ST_MUL_ISSUE;
            end
            agbkf_pkg::ST_MUL_ISSUE:
            begin
                cmd.mul_issue = 1'b1;
                state_next    = agbkf_pkg::ST_MUL_WAIT;
            end
            agbkf_pkg::ST_MUL_WAIT:
            begin
                state_next = agbkf_pkg::ST_MUL_WB;
            end
            agbkf_pkg::ST_MUL_WB:
            begin
                cmd.mul_wb = 1'b1;
                op_next    = next_op(op_reg);
                if (op_reg == agbkf_pkg::MOP_P11_PRED)
                    state_next = agbkf_pkg::ST_GAIN;
                else if (op_reg == agbkf_pkg::MOP_P00)
                    state_next = agbkf_pkg::ST_DONE;
                else
                    state_next = agbkf_pkg::ST_MUL_ISSUE;
            end
            agbkf_pkg::ST_GAIN:
            begin
                cmd.gain = 1'b1;
                sel_next = 1'b0;
                // The skip flag is registered at the end of this state, so the
                // choice between dividing and skipping is made in the next one.
                state_next = agbkf_pkg::ST_DIV_START;
            end
            agbkf_pkg::ST_DIV_START:
            begin
                if (status.skip)
                    state_next = agbkf_pkg::ST_MUL_ISSUE;
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = agbkf_pkg::ST_DIV_STEP;
                end
            end
            agbkf_pkg::ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == agbkf_pkg::DIV_CNT_W'(agbkf_pkg::DIV_W - 1))
                    state_next = agbkf_pkg::ST_DIV_WB;
            end
            agbkf_pkg::ST_DIV_WB:
            begin
                cmd.div_wb = 1'b1;
                if (sel_reg)
                    state_next = agbkf_pkg::ST_MUL_ISSUE;
                else
                begin
                    sel_next   = 1'b1;
                    state_next = agbkf_pkg::ST_DIV_START;
                end
            end
            agbkf_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = agbkf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = agbkf_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != agbkf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/agbkf_dpath.sv
// Filter state, shared multiplier, bit-serial gain divider and result register.
module agbkf_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  agbkf_pkg::cfg_t       cfg,
    input  logic                  reload,
    input  agbkf_pkg::in_data_t   in_data,
    input  agbkf_pkg::dp_cmd_t    cmd,
    output agbkf_pkg::dp_status_t status,
    output agbkf_pkg::out_data_t  out_data
);

    logic signed [31:0] angle_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [agbkf_pkg::DT_W-1:0] dt_reg;
    logic signed [31:0] meas_reg, rate_reg;
    logic signed [31:0] tmp_reg, y_reg, k0_reg, k1_reg;
    logic signed [33:0] s_reg;
    logic               skip_reg;
    logic signed [32:0] op_a_reg;
    logic signed [31:0] op_b_reg;
    logic               q24_reg;
    logic signed [64:0] prod_reg;
    logic [31:0]        rem_reg;
    logic [agbkf_pkg::DIV_W-1:0] num_reg, quo_reg;
    logic               neg_reg;
    agbkf_pkg::out_data_t out_reg;

    logic signed [64:0] prod_sh;
    logic signed [31:0] m;
    logic signed [32:0] op_a_dt;
    logic signed [31:0] u;
    logic [32:0]        trial;
    logic signed [31:0] p_div;
    logic [31:0]        p_mag;
    logic signed [31:0] q_sat;
    logic signed [31:0] s_new_chk;

    assign op_a_dt = $signed({9'd0, dt_reg});
    assign prod_sh = q24_reg ? (prod_reg >>> agbkf_pkg::COV_FRAC)
                             : (prod_reg >>> agbkf_pkg::DT_FRAC);
    assign m       = agbkf_pkg::sat32(66'(prod_sh));
    assign u       = agbkf_pkg::sat32(66'(tmp_reg) - 66'(p01_reg) - 66'(p10_reg)
                                      + $signed({35'd0, cfg.qa}));
    assign trial   = {rem_reg, num_reg[agbkf_pkg::DIV_W-1]};
    assign p_div   = cmd.div_sel ? p10_reg : p00_reg;
    assign p_mag   = p_div[31] ? 32'(-p_div) : p_div;
    assign q_sat   = neg_reg ? agbkf_pkg::sat32(-$signed({10'd0, quo_reg}))
                             : agbkf_pkg::sat32($signed({10'd0, quo_reg}));
    assign s_new_chk = 32'sd0;

    // Multiplier pipe: operands are registered at issue, and the product is registered in the cycle after.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a_reg * op_b_reg;
        if (cmd.mul_issue)
        begin
            unique case (cmd.mul_op)
                agbkf_pkg::MOP_ANG_PRED: begin op_a_reg <= op_a_dt; op_b_reg <= tmp_reg; end
                agbkf_pkg::MOP_T:        begin op_a_reg <= op_a_dt; op_b_reg <= p11_reg; end
                agbkf_pkg::MOP_P00_PRED: begin op_a_reg <= op_a_dt; op_b_reg <= u; end
                agbkf_pkg::MOP_P11_PRED:
                begin
                    op_a_reg <= op_a_dt;
                    op_b_reg <= $signed({1'b0, cfg.qb});
                end
                agbkf_pkg::MOP_ANG_COR:  begin op_a_reg <= 33'(k0_reg); op_b_reg <= y_reg; end
                agbkf_pkg::MOP_BIAS:     begin op_a_reg <= 33'(k1_reg); op_b_reg <= y_reg; end
                agbkf_pkg::MOP_P11:      begin op_a_reg <= 33'(k1_reg); op_b_reg <= p01_reg; end
                agbkf_pkg::MOP_P10:      begin op_a_reg <= 33'(k1_reg); op_b_reg <= p00_reg; end
                agbkf_pkg::MOP_P01:      begin op_a_reg <= 33'(k0_reg); op_b_reg <= p01_reg; end
                default:                 begin op_a_reg <= 33'(k0_reg); op_b_reg <= p00_reg; end
            endcase
            q24_reg <= (cmd.mul_op == agbkf_pkg::MOP_ANG_COR) || (cmd.mul_op == agbkf_pkg::MOP_BIAS)
                    || (cmd.mul_op == agbkf_pkg::MOP_P11) || (cmd.mul_op == agbkf_pkg::MOP_P10)
                    || (cmd.mul_op == agbkf_pkg::MOP_P01) || (cmd.mul_op == agbkf_pkg::MOP_P00);
        end

        if (cmd.load)
        begin
            dt_reg   <= in_data.time_step;
            meas_reg <= in_data.measured_angle;
            rate_reg <= in_data.measured_rate;
        end
        if (cmd.prep)
            tmp_reg <= agbkf_pkg::sat32(66'(rate_reg) - 66'(bias_reg));
        if (cmd.mul_wb && cmd.mul_op == agbkf_pkg::MOP_T)
            tmp_reg <= m;
        if (cmd.gain)
        begin
            y_reg <= agbkf_pkg::sat32(66'(meas_reg) - 66'(angle_reg));
            s_reg <= 34'(p00_reg) + $signed({3'd0, cfg.r});
            k0_reg <= s_new_chk;
            k1_reg <= s_new_chk;
        end

        // Restoring divider on magnitudes, one quotient bit a cycle.
        if (cmd.div_start)
        begin
            num_reg <= {p_mag, {agbkf_pkg::COV_FRAC{1'b0}}};
            neg_reg <= p_div[31];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[agbkf_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, s_reg[31:0]})
            begin
                rem_reg <= 32'(trial - {1'b0, s_reg[31:0]});
                quo_reg <= {quo_reg[agbkf_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[agbkf_pkg::DIV_W-2:0], 1'b0};
            end
        end
        if (cmd.div_wb)
        begin
            if (cmd.div_sel)
                k1_reg <= q_sat;
            else
                k0_reg <= q_sat;
        end

        if (cmd.emit)
        begin
            out_reg.angle_estimate <= angle_reg;
            out_reg.gain_skipped   <= skip_reg;
        end
    end

    // Filter state: reset and any configuration write load the initial values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= agbkf_pkg::RST_ANG;
            bias_reg  <= agbkf_pkg::RST_BIAS;
            p00_reg   <= agbkf_pkg::RST_COVA;
            p01_reg   <= agbkf_pkg::RST_COVX;
            p10_reg   <= agbkf_pkg::RST_COVX;
            p11_reg   <= agbkf_pkg::RST_COVB;
            skip_reg  <= 1'b0;
        end
        else if (reload)
        begin
            angle_reg <= cfg.init_angle;
            bias_reg  <= cfg.init_bias;
            p00_reg   <= cfg.init_cov_a;
            p01_reg   <= cfg.init_cov_x;
            p10_reg   <= cfg.init_cov_x;
            p11_reg   <= cfg.init_cov_b;
        end
        else
        begin
            if (cmd.gain)
                skip_reg <= (34'(p00_reg) + $signed({3'd0, cfg.r})) <= 34'sd0;
            if (cmd.mul_wb)
            begin
                unique case (cmd.mul_op)
                    agbkf_pkg::MOP_ANG_PRED, agbkf_pkg::MOP_ANG_COR:
                        angle_reg <= agbkf_pkg::sat32(66'(angle_reg) + 66'(m));
                    agbkf_pkg::MOP_T:
                        angle_reg <= angle_reg;
                    agbkf_pkg::MOP_P00_PRED:
                    begin
                        p00_reg <= agbkf_pkg::sat32(66'(p00_reg) + 66'(m));
                        p01_reg <= agbkf_pkg::sat32(66'(p01_reg) - 66'(tmp_reg));
                        p10_reg <= agbkf_pkg::sat32(66'(p10_reg) - 66'(tmp_reg));
                    end
                    agbkf_pkg::MOP_P11_PRED:
                        p11_reg <= agbkf_pkg::sat32(66'(p11_reg) + 66'(m));
                    agbkf_pkg::MOP_BIAS:
                        bias_reg <= agbkf_pkg::sat32(66'(bias_reg) + 66'(m));
                    agbkf_pkg::MOP_P11:
                        p11_reg <= agbkf_pkg::sat32(66'(p11_reg) - 66'(m));
                    agbkf_pkg::MOP_P10:
                        p10_reg <= agbkf_pkg::sat32(66'(p10_reg) - 66'(m));
                    agbkf_pkg::MOP_P01:
                        p01_reg <= agbkf_pkg::sat32(66'(p01_reg) - 66'(m));
                    default:
                        p00_reg <= agbkf_pkg::sat32(66'(p00_reg) - 66'(m));
                endcase
            end
        end
    end

    assign status.skip = skip_reg;
    assign out_data    = out_reg;

endmodule

FILE: hdl/angle_gyro_bias_kalman_filter_core.sv
// Top level of the two-state angle and gyro bias Kalman filter.
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid / in_stall  in_data (time step, measured angle and rate)
//  out       output     out_valid/out_stall  out_data (angle estimate, gain skipped flag)
//  cfg       input      APB-style write/read eight registers at byte address 4*i
//
// One request at a time. An update runs ten multiplies, each issued, awaited and
// written back in turn on the single shared multiplier, and, unless the gain is
// skipped, two bit-serial divisions (start, one step per bit of the 56-bit
// quotient, write-back).
// A new request is taken while the previous result still waits under out_stall.
// Reset and every configuration write reload the estimates and covariance from
// the initial-value registers; the write is first registered as a reload pulse.
module angle_gyro_bias_kalman_filter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  agbkf_pkg::in_data_t          in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output agbkf_pkg::out_data_t         out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [agbkf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    agbkf_pkg::cfg_t       cfg;
    logic                  reload;
    agbkf_pkg::dp_cmd_t    cmd;
    agbkf_pkg::dp_status_t status;

    // The register file never inserts wait states.
    assign pready = 1'b1;

    agbkf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .reload  (reload)
    );

    // The controller owns the handshakes and sequences every step of the update.
    agbkf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the filter state and the arithmetic units.
    agbkf_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .reload   (reload),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

FILE: hdl/agbkf_checker.sv
// Port-level checks on the filter core, bound to the top level.
module agbkf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input agbkf_pkg::out_data_t out_data,
    input logic                 pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind angle_gyro_bias_kalman_filter_core agbkf_checker u_agbkf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pready    (pready)
);
